// ===== rtl/core/crw_pkg.sv =====
// ----------------------------------------------------------------------------
// crw_pkg: shared types and constants for the chunk reorder window
// Result kinds, controller states, command/status bundles and window helpers.
// ----------------------------------------------------------------------------
package crw_pkg;

   localparam int MAX_WINDOW  = 32;
   localparam int SLOT_W      = $clog2(MAX_WINDOW);
   localparam int WIN_W       = 6;
   localparam int SEQ_W       = 32;
   localparam int LEN_W       = 16;
   localparam int KIND_W      = 2;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_USER_W  = 3;

   localparam logic [WIN_W-1:0] DEFAULT_WINDOW = 6'd8;
   localparam logic [WIN_W-1:0] MAX_WINDOW_W   = 6'(MAX_WINDOW);
   localparam logic [SEQ_W-1:0] FINAL_SEQ      = 32'hFFFF_FFFF;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TAIL    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REREQ   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_TAIL
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic insert;
      logic emit_deliver;
      logic emit_rereq;
      logic emit_tail;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_window;
      logic head_filled;
      logic tail_ovf;
      logic walk_end;
      logic tail_end;
      logic out_free;
   } status_type;

   // effective window depth: zero reads as the default, large values saturate
   function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] r;
      r = w;
      if (w == '0) begin
         r = DEFAULT_WINDOW;
      end else if (w > MAX_WINDOW_W) begin
         r = MAX_WINDOW_W;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/chunk_reorder_window.sv =====
// ----------------------------------------------------------------------------
// chunk_reorder_window: receive-side reorder window for numbered chunks
// Top level joining the walk sequencer and the window datapath.
// ----------------------------------------------------------------------------
// Accepts one chunk (number, length) per item and answers with the in-order
// releases it unlocks: for each filled head slot a deliver item followed by a
// request for the new tail chunk (left out past the last chunk number), and a
// re-request of the head chunk at the first gap. A chunk outside the window
// is dropped in the cycle it is taken and gives no result. An in-window item
// is taken while the sequencer is idle, then the walk sequencer puts out one
// result item per cycle through the output register while rsp_tready does
// not stall it, up to 2W results for one item; the next item is taken once
// the walk has issued its last result. Payload bytes belong in an external
// store addressed by the slot field.
module chunk_reorder_window (
   input  logic                              clock,
   input  logic                              reset,
   // fields from bit 0: chunk_number[31:0], payload_length[47:32]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [crw_pkg::REQ_DATA_W-1:0]    req_tdata,
   // fields from bit 0: sequence_res[31:0], slot[36:32], length[52:37], zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [crw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // fields from bit 0: kind[1:0], done_res[2]
   output logic [crw_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast,
   // window_size register
   input  logic                              csr_wen,
   input  logic [crw_pkg::WIN_W-1:0]         csr_wdata
);

   crw_pkg::cmd_type    cmd;
   crw_pkg::status_type status;

   crw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   crw_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/crw_ctrl.sv =====
// ----------------------------------------------------------------------------
// crw_ctrl: release walk sequencer
// Accepts one item at a time and steps the walk one result per unstalled cycle.
// ----------------------------------------------------------------------------
module crw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  crw_pkg::status_type   status,
   output crw_pkg::cmd_type      cmd
);

   crw_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crw_pkg::ST_IDLE: begin
            if (req_tvalid && status.in_window) begin
               state_in = crw_pkg::ST_WALK;
            end
         end
         crw_pkg::ST_WALK: begin
            if (status.out_free) begin
               if (!status.head_filled) begin
                  state_in = crw_pkg::ST_IDLE;
               end else if (!status.tail_ovf) begin
                  state_in = crw_pkg::ST_TAIL;
               end else if (status.walk_end) begin
                  state_in = crw_pkg::ST_IDLE;
               end
            end
         end
         crw_pkg::ST_TAIL: begin
            if (status.out_free) begin
               state_in = status.tail_end ? crw_pkg::ST_IDLE : crw_pkg::ST_WALK;
            end
         end
         default: state_in = crw_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready       = 1'b0;
      cmd              = '0;
      case (state_ff)
         crw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.insert = req_tvalid && status.in_window;
         end
         crw_pkg::ST_WALK: begin
            cmd.emit_deliver = status.out_free && status.head_filled;
            cmd.emit_rereq   = status.out_free && !status.head_filled;
         end
         crw_pkg::ST_TAIL: begin
            cmd.emit_tail = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/crw_datapath.sv =====
// ----------------------------------------------------------------------------
// crw_datapath: window state, slot store and result register
// Holds head, fill flags, stored lengths and the registered result item.
// ----------------------------------------------------------------------------
module crw_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [crw_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              csr_wen,
   input  logic [crw_pkg::WIN_W-1:0]         csr_wdata,
   input  crw_pkg::cmd_type                  cmd,
   output crw_pkg::status_type               status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [crw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [crw_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int SLOT_W = crw_pkg::SLOT_W;
   localparam int SEQ_W  = crw_pkg::SEQ_W;
   localparam int LEN_W  = crw_pkg::LEN_W;
   localparam int WIN_W  = crw_pkg::WIN_W;

   logic [SEQ_W-1:0]            head_seq_ff, head_seq_in;
   logic [SLOT_W-1:0]           head_slot_ff, head_slot_in;
   logic [crw_pkg::MAX_WINDOW-1:0] filled_ff, filled_in;
   logic [WIN_W-1:0]            win_ff;
   logic [WIN_W-1:0]            count_ff, count_in;
   logic [LEN_W-1:0]            len_mem [crw_pkg::MAX_WINDOW];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [crw_pkg::KIND_W-1:0]  rsp_kind_ff;
   logic [SEQ_W-1:0]            rsp_seq_ff;
   logic [SLOT_W-1:0]           rsp_slot_ff;
   logic [LEN_W-1:0]            rsp_len_ff;
   logic                        rsp_done_ff;
   logic                        rsp_last_ff;

   logic [SEQ_W-1:0]            in_chunk;
   logic [LEN_W-1:0]            in_len;
   logic [SEQ_W-1:0]            diff;
   logic [SLOT_W-1:0]           ins_slot;
   logic [WIN_W-1:0]            win_eff;
   logic [WIN_W-1:0]            win_new_eff;
   logic [SEQ_W:0]              tail_sum;
   logic                        any_emit;

   assign in_chunk    = req_tdata[SEQ_W-1:0];
   assign in_len      = req_tdata[SEQ_W+LEN_W-1:SEQ_W];
   assign win_eff     = crw_pkg::eff_window(win_ff);
   assign win_new_eff = crw_pkg::eff_window(csr_wdata);

   // window test and target slot of the arriving chunk
   assign diff     = in_chunk - head_seq_ff;
   assign ins_slot = head_slot_ff + diff[SLOT_W-1:0];

   // tail chunk after a slide is head + W; past the last number when it carries
   assign tail_sum = {1'b0, head_seq_ff} + (SEQ_W+1)'(win_eff);
   assign any_emit = cmd.emit_deliver || cmd.emit_rereq || cmd.emit_tail;

   // status to the controller
   always_comb begin
      status.in_window   = (in_chunk >= head_seq_ff) && (diff < SEQ_W'(win_eff));
      status.head_filled = filled_ff[head_slot_ff];
      status.tail_ovf    = tail_sum[SEQ_W];
      status.walk_end    = (count_ff + WIN_W'(1)) == win_eff;
      status.tail_end    = count_ff == win_eff;
      status.out_free    = !rsp_valid_ff || rsp_tready;
   end

   // window register
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= crw_pkg::DEFAULT_WINDOW;
      end else if (csr_wen) begin
         win_ff <= csr_wdata;
      end
   end

   // fill flags: resize clears slots outside the window, insert sets, deliver frees
   always_comb begin
      logic [SLOT_W-1:0] off;
      off       = '0;
      filled_in = filled_ff;
      if (csr_wen) begin
         for (int j = 0; j < crw_pkg::MAX_WINDOW; j++) begin
            off = SLOT_W'(j) - head_slot_ff;
            if ({1'b0, off} >= win_new_eff) begin
               filled_in[j] = 1'b0;
            end
         end
      end
      if (cmd.insert) begin
         filled_in[ins_slot] = 1'b1;
      end
      if (cmd.emit_deliver) begin
         filled_in[head_slot_ff] = 1'b0;
      end
   end

   // head and walk count
   always_comb begin
      head_seq_in  = head_seq_ff;
      head_slot_in = head_slot_ff;
      count_in     = count_ff;
      if (cmd.insert) begin
         count_in = '0;
      end
      if (cmd.emit_deliver) begin
         head_seq_in  = head_seq_ff + SEQ_W'(1);
         head_slot_in = head_slot_ff + SLOT_W'(1);
         count_in     = count_ff + WIN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_seq_ff  <= '0;
         head_slot_ff <= '0;
         filled_ff    <= '0;
         count_ff     <= '0;
      end else begin
         head_seq_ff  <= head_seq_in;
         head_slot_ff <= head_slot_in;
         filled_ff    <= filled_in;
         count_ff     <= count_in;
      end
   end

   // length store: first arrival of a chunk writes its slot
   always_ff @(posedge clock) begin
      if (cmd.insert && !filled_ff[ins_slot]) begin
         len_mem[ins_slot] <= in_len;
      end
   end

   // result register
   assign rsp_valid_in = any_emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_deliver) begin
         rsp_kind_ff <= crw_pkg::KIND_DELIVER;
         rsp_seq_ff  <= head_seq_ff;
         rsp_slot_ff <= head_slot_ff;
         rsp_len_ff  <= len_mem[head_slot_ff];
         rsp_done_ff <= head_seq_ff == crw_pkg::FINAL_SEQ;
         rsp_last_ff <= tail_sum[SEQ_W] && ((count_ff + WIN_W'(1)) == win_eff);
      end else if (cmd.emit_rereq) begin
         rsp_kind_ff <= crw_pkg::KIND_REREQ;
         rsp_seq_ff  <= head_seq_ff;
         rsp_slot_ff <= head_slot_ff;
         rsp_len_ff  <= '0;
         rsp_done_ff <= 1'b0;
         rsp_last_ff <= 1'b1;
      end else if (cmd.emit_tail) begin
         rsp_kind_ff <= crw_pkg::KIND_TAIL;
         rsp_seq_ff  <= head_seq_ff + SEQ_W'(win_eff) - SEQ_W'(1);
         rsp_slot_ff <= head_slot_ff + win_eff[SLOT_W-1:0] - SLOT_W'(1);
         rsp_len_ff  <= '0;
         rsp_done_ff <= 1'b0;
         rsp_last_ff <= count_ff == win_eff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_len_ff, rsp_slot_ff, rsp_seq_ff};
   assign rsp_tuser  = {rsp_done_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/crw_checker.sv =====
// ----------------------------------------------------------------------------
// crw_checker: port-level checks for the chunk reorder window
// Watches the result channel and is bound onto the top level.
// ----------------------------------------------------------------------------
module crw_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [crw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic [crw_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                              rsp_tlast
);

   // a stalled result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item withdrawn while stalled");

   // a re-request always closes the walk
   a_rereq_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == crw_pkg::KIND_REREQ) |-> rsp_tlast)
      else $error("re-request not marked last");

   // requests carry no length and never flag done
   a_req_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] != crw_pkg::KIND_DELIVER)
      |-> (rsp_tdata[52:37] == '0) && !rsp_tuser[2])
      else $error("request with length or done set");

   // done only on delivery of the final chunk number
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2]
      |-> (rsp_tuser[1:0] == crw_pkg::KIND_DELIVER)
          && (rsp_tdata[31:0] == crw_pkg::FINAL_SEQ))
      else $error("done on wrong item");

   // no kind code beyond the three defined
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[1:0] == crw_pkg::KIND_DELIVER)
                  || (rsp_tuser[1:0] == crw_pkg::KIND_TAIL)
                  || (rsp_tuser[1:0] == crw_pkg::KIND_REREQ))
      else $error("undefined result kind");

endmodule

bind chunk_reorder_window crw_checker u_crw_checker (.*);
